@@ sv/assert_macros.svh @@
// Assertion macros shared by the scanner RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BPS_ASSERT(label, clk, rst_n, prop, msg)
`define BPS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ sv/bps_pkg.sv @@
// Package for the boundary pattern scanner: constants, register codes and
// the structs passed between the register block, the engine and the top level.
package bps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int PATTERN_BYTES   = 32;
    localparam int LEN_BITS        = 6;
    localparam int ADDR_BITS       = 6;
    localparam int DATA_BITS       = 64;

    typedef enum logic [2:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD_0 = 3'd1,
        REG_PATTERN_WORD_1 = 3'd2,
        REG_PATTERN_WORD_2 = 3'd3,
        REG_PATTERN_WORD_3 = 3'd4
    } reg_idx_t;

    // byte j of the pattern is pattern[j]; eight bytes per register word
    typedef struct packed {
        logic [LEN_BITS-1:0]            pattern_length;
        logic [PATTERN_BYTES-1:0][7:0]  pattern;
    } cfg_t;

    typedef struct packed {
        logic                func;
        logic [7:0]          data_byte;
        logic                chunk_end;
        logic [LEN_BITS-1:0] pre_matched;
    } item_t;

endpackage

@@ sv/bps_cfg.sv @@
// APB register block of the scanner: pattern length and four pattern words.
// Depends on bps_pkg.
module bps_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bps_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [bps_pkg::DATA_BITS-1:0]  pwdata,
    output logic [bps_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output bps_pkg::cfg_t                  cfg
);

    bps_pkg::cfg_t     cfg_reg;
    bps_pkg::reg_idx_t reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = bps_pkg::reg_idx_t'(paddr[5:3]);
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                bps_pkg::REG_PATTERN_LENGTH: cfg_reg.pattern_length <= pwdata[5:0];
                bps_pkg::REG_PATTERN_WORD_0: cfg_reg.pattern[7:0]   <= pwdata;
                bps_pkg::REG_PATTERN_WORD_1: cfg_reg.pattern[15:8]  <= pwdata;
                bps_pkg::REG_PATTERN_WORD_2: cfg_reg.pattern[23:16] <= pwdata;
                bps_pkg::REG_PATTERN_WORD_3: cfg_reg.pattern[31:24] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            bps_pkg::REG_PATTERN_LENGTH: prdata = 64'(cfg_reg.pattern_length);
            bps_pkg::REG_PATTERN_WORD_0: prdata = cfg_reg.pattern[7:0];
            bps_pkg::REG_PATTERN_WORD_1: prdata = cfg_reg.pattern[15:8];
            bps_pkg::REG_PATTERN_WORD_2: prdata = cfg_reg.pattern[23:16];
            bps_pkg::REG_PATTERN_WORD_3: prdata = cfg_reg.pattern[31:24];
            default:                     prdata = '0;
        endcase
    end

endmodule

@@ sv/bps_engine.sv @@
// Match engine: shift-and prefix vector, continue-mode tracker and chunk
// bookkeeping, one byte per cycle on adv. Depends on bps_pkg, assert_macros.svh.
`include "assert_macros.svh"
module bps_engine
#(
    parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_BITS  = bps_pkg::COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  bps_pkg::item_t        item,
    input  bps_pkg::cfg_t         cfg,
    output logic                  res_fire,
    output logic [COUNT_BITS-1:0] res_count
);

    localparam int CAP = (PATTERN_MAX < bps_pkg::PATTERN_BYTES) ?
                         PATTERN_MAX : bps_pkg::PATTERN_BYTES;
    localparam logic [bps_pkg::LEN_BITS-1:0] CAP_L     = bps_pkg::LEN_BITS'(CAP);
    localparam logic [COUNT_BITS-1:0]        COUNT_MAX = '1;

    logic [CAP-1:0]               alive_reg, alive_next;
    logic [COUNT_BITS-1:0]        pos_reg, pos_next;
    logic                         fmf_reg, fmf_next;
    logic [COUNT_BITS-1:0]        fmo_reg, fmo_next;
    logic                         ca_reg, ca_next;
    logic [bps_pkg::LEN_BITS-1:0] co_reg, co_next;
    logic                         mode_reg, mode_next;

    logic [bps_pkg::LEN_BITS-1:0] len, tail;
    logic                         first, sat, cont_ok, full_bit, full_hit, tail_hit;
    logic [COUNT_BITS-1:0]        n;
    logic [CAP-1:0]               alive_prev, alive_sh, mask;
    logic                         fmf_prev, ca_prev;
    logic [COUNT_BITS-1:0]        fmo_prev;
    logic [bps_pkg::LEN_BITS-1:0] co_prev;

    always_comb
    begin
        len     = (cfg.pattern_length < CAP_L) ? cfg.pattern_length : CAP_L;
        first   = (pos_reg == '0);
        sat     = (pos_reg == COUNT_MAX);
        n       = sat ? COUNT_MAX : pos_reg + COUNT_BITS'(1);
        cont_ok = item.func && (len != '0) && (item.pre_matched < len);

        // a new chunk starts from clean state
        mode_next  = first ? item.func : mode_reg;
        alive_prev = first ? '0 : alive_reg;
        fmf_prev   = first ? 1'b0 : fmf_reg;
        fmo_prev   = first ? '0 : fmo_reg;
        ca_prev    = first ? cont_ok : ca_reg;
        co_prev    = first ? (cont_ok ? item.pre_matched : '0) : co_reg;

        for (int k = 0; k < CAP; k++)
        begin
            mask[k] = (bps_pkg::LEN_BITS'(k) < len) && (cfg.pattern[k] == item.data_byte);
        end
        alive_sh    = alive_prev << 1;
        alive_sh[0] = 1'b1;
        alive_next  = mode_next ? alive_prev : (alive_sh & mask);

        full_bit = 1'b0;
        for (int k = 0; k < CAP; k++)
        begin
            if (bps_pkg::LEN_BITS'(k + 1) == len)
            begin
                full_bit = alive_next[k];
            end
        end
        full_hit = !mode_next && (len != '0) && !fmf_prev && full_bit;
        fmf_next = fmf_prev || full_hit;
        fmo_next = fmo_prev;
        if (full_hit)
        begin
            fmo_next = (sat || n < COUNT_BITS'(len)) ? COUNT_MAX : n - COUNT_BITS'(len);
        end

        ca_next = ca_prev;
        co_next = co_prev;
        if (mode_next && ca_prev && co_prev < len)
        begin
            if (cfg.pattern[co_prev[4:0]] == item.data_byte)
            begin
                co_next = co_prev + bps_pkg::LEN_BITS'(1);
            end
            else
            begin
                ca_next = 1'b0;
            end
        end

        // longest live proper prefix marks the earliest matching tail
        tail_hit = 1'b0;
        tail     = '0;
        for (int k = 0; k < CAP; k++)
        begin
            if (bps_pkg::LEN_BITS'(k + 1) < len && alive_next[k])
            begin
                tail_hit = 1'b1;
                tail     = bps_pkg::LEN_BITS'(k + 1);
            end
        end

        if (mode_next)
        begin
            res_count = ca_next ? COUNT_BITS'(co_next) : '0;
        end
        else if (len == '0)
        begin
            res_count = n;
        end
        else if (fmf_next)
        begin
            res_count = fmo_next;
        end
        else if (tail_hit)
        begin
            res_count = (sat || n < COUNT_BITS'(tail)) ? COUNT_MAX : n - COUNT_BITS'(tail);
        end
        else
        begin
            res_count = n;
        end

        pos_next = item.chunk_end ? '0 : n;
        res_fire = adv && item.chunk_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= '0;
            pos_reg   <= '0;
            fmf_reg   <= 1'b0;
            fmo_reg   <= '0;
            ca_reg    <= 1'b0;
            co_reg    <= '0;
            mode_reg  <= 1'b0;
        end
        else if (adv)
        begin
            alive_reg <= alive_next;
            pos_reg   <= pos_next;
            fmf_reg   <= fmf_next;
            fmo_reg   <= fmo_next;
            ca_reg    <= ca_next;
            co_reg    <= co_next;
            mode_reg  <= mode_next;
        end
    end

    `BPS_ASSERT(a_pos_clears_after_end, clk, rst_n, res_fire |=> pos_reg == '0, "chunk position not cleared after last byte")
    `BPS_ASSERT_NEVER(a_co_in_range, clk, rst_n, co_reg > CAP_L, "continue offset beyond pattern capacity")
    `BPS_ASSERT(a_cont_no_prefix, clk, rst_n, (mode_reg && pos_reg != '0) |-> alive_reg == '0, "prefix vector live in continue chunk")

endmodule

@@ sv/boundary_pattern_scanner_top.sv @@
// Top level of the boundary pattern scanner: input stage, match engine,
// result register and APB registers. Depends on bps_pkg, bps_cfg, bps_engine.
//
// Takes one chunk byte per clock while no chunk-ending byte waits on an untaken
// result, with valid/ready on both sides. A byte is registered in the input
// stage on acceptance and goes through the match engine from there; on the byte
// flagged chunk_end the result lands in the output register, and result_count
// is valid once that register holds it. All pattern positions are compared
// against each byte in parallel in the match engine; the output register
// lets new bytes flow while a result waits, and only the next last byte
// stalls behind an untaken result.
// Patterns up to PATTERN_MAX bytes (at most 32); offsets saturate at
// 2**COUNT_BITS-1. Registers are 64 bits at byte address 8*i.
`include "assert_macros.svh"
module boundary_pattern_scanner_top
#(
    parameter int PATTERN_MAX = bps_pkg::PATTERN_MAX_DEF,
    parameter int COUNT_BITS  = bps_pkg::COUNT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [7:0]                    data_byte,
    input  logic                          chunk_end,
    input  logic [bps_pkg::LEN_BITS-1:0]  pre_matched,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COUNT_BITS-1:0]         result_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bps_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bps_pkg::DATA_BITS-1:0] pwdata,
    output logic [bps_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    bps_pkg::cfg_t         cfg;
    bps_pkg::item_t        s1_item_reg;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0] result_count_reg;
    logic                  adv, res_fire;
    logic [COUNT_BITS-1:0] res_count;

    bps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bps_engine #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .item      (s1_item_reg),
        .cfg       (cfg),
        .res_fire  (res_fire),
        .res_count (res_count)
    );

    // only a chunk-ending byte needs room in the result register
    assign adv      = s1_valid_reg && (!s1_item_reg.chunk_end || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;

    assign out_valid    = out_valid_reg;
    assign result_count = result_count_reg;

    always_comb
    begin
        s1_valid_next = in_valid || (s1_valid_reg && !adv);
        if (res_fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg.func        <= func;
            s1_item_reg.data_byte   <= data_byte;
            s1_item_reg.chunk_end   <= chunk_end;
            s1_item_reg.pre_matched <= pre_matched;
        end
        if (res_fire)
        begin
            result_count_reg <= res_count;
        end
    end

    `BPS_ASSERT(a_accept_lands, clk, rst_n, (in_valid && in_ready) |=> s1_valid_reg, "accepted transaction not held in input stage")
    `BPS_ASSERT(a_result_held, clk, rst_n, (out_valid_reg && !out_ready) |=> out_valid_reg, "pending result dropped")
    `BPS_ASSERT_NEVER(a_no_overwrite, clk, rst_n, res_fire && out_valid_reg && !out_ready, "result overwritten before taken")

endmodule
